### src/grm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_pkg
// Shared widths, codes and types of the gated RMS / DC / Vpp meter.
// ----------------------------------------------------------------------------
package grm_pkg;

    localparam int ADC_BITS   = 14;
    localparam int TIMER_BITS = 16;

    // sample to millivolt conversion: (MV_SCALE*(s-MV_MID))/MV_MID - MV_TRIM
    localparam int MID_SH   = ADC_BITS - 1;
    localparam int MV_MID   = 2**MID_SH - 1;
    localparam int MV_SCALE = 6596;
    localparam int MV_TRIM  = 3;

    localparam int MAG_W    = 13;               // |mV|
    localparam int MV_W     = MAG_W + 1;        // signed mV
    localparam int PROD_W   = MAG_W + MID_SH + 1;
    localparam int SQ_W     = 2 * MAG_W;        // square, mean square
    localparam int SQSUM_W  = 42;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 16;
    localparam int OVF_W    = 16;
    localparam int OFS_W    = 10;
    localparam int PERIOD_W = 32;
    localparam int DIV_W    = SQSUM_W;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVF_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_OFFSET = 1'b1;
    localparam logic [CFG_W-1:0] OVF_LIMIT_RST  = 16'd756;
    localparam logic [OFS_W-1:0] CAP_OFFSET_RST = 10'd149;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int IN_TDATA_W  = ((ADC_BITS + TIMER_BITS + 7) / 8) * 8;
    localparam int RES_W       = MAG_W + 2 * MV_W + PERIOD_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_OVF     = 2'd1,
        OP_CAP     = 2'd2,
        OP_OVF_CAP = 2'd3
    } t_op;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
    } t_cfg_wr;

    typedef struct packed {
        t_op                    op;
        logic signed [MV_W-1:0] mv;
        logic [MAG_W-1:0]       mag;
        logic [TIMER_BITS-1:0]  cap;
    } t_item;

    typedef struct packed {
        logic                   done;
        logic                   gate;
        logic [PERIOD_W-1:0]    period;
        logic [MV_W-1:0]        vpp;
        logic signed [MV_W-1:0] dc;
        logic [MAG_W-1:0]       rms;
    } t_result;

endpackage
`default_nettype wire

### src/grm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_front
// Input stage: takes transfers, scales ADC codes to millivolts and pushes
// classified items into the queue.
// ----------------------------------------------------------------------------
module grm_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_vld,
    output logic                                 o_ready,
    input  wire grm_pkg::t_op                    i_op,
    input  wire logic [grm_pkg::ADC_BITS-1:0]    i_sample,
    input  wire logic [grm_pkg::TIMER_BITS-1:0]  i_cap,
    input  wire logic                            i_q_ready,
    output logic                                 o_push,
    output grm_pkg::t_item                       o_item
);
    import grm_pkg::*;

    localparam logic signed [MV_W:0] SCALE_S = (MV_W + 1)'(MV_SCALE);

    logic signed [ADC_BITS:0] w_diff;
    logic signed [PROD_W-1:0] w_prod;

    logic                     r_vld;
    t_op                      r_op;
    logic signed [PROD_W-1:0] r_prod;
    logic [TIMER_BITS-1:0]    r_cap;

    logic                     w_neg;
    logic [PROD_W-2:0]        w_abs;
    logic [MAG_W-1:0]         w_qest;
    logic [MID_SH:0]          w_rem;
    logic [MAG_W-1:0]         w_q;
    logic signed [MV_W-1:0]   w_qs;
    logic signed [MV_W-1:0]   w_mv;
    logic [MAG_W-1:0]         w_mag;

    assign w_diff  = $signed({1'b0, i_sample}) - $signed((ADC_BITS + 1)'(MV_MID));
    assign w_prod  = w_diff * SCALE_S;
    assign o_ready = !r_vld || i_q_ready;
    assign o_push  = r_vld && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_op   <= i_op;
            r_prod <= w_prod;
            r_cap  <= i_cap;
        end
    end

    // divide by 2^k-1: estimate by shift, remainder stays below twice the divisor
    assign w_neg  = r_prod[PROD_W-1];
    assign w_abs  = w_neg ? (PROD_W - 1)'(-r_prod) : r_prod[PROD_W-2:0];
    assign w_qest = MAG_W'(w_abs >> MID_SH);
    assign w_rem  = {1'b0, w_abs[MID_SH-1:0]} + (MID_SH + 1)'(w_qest);
    assign w_q    = w_qest + MAG_W'(w_rem >= (MID_SH + 1)'(MV_MID));
    assign w_qs   = w_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_mv   = w_qs - MV_W'(MV_TRIM);
    assign w_mag  = w_mv[MV_W-1] ? MAG_W'(-w_mv) : w_mv[MAG_W-1:0];

    always_comb begin
        o_item.op  = r_op;
        o_item.mv  = w_mv;
        o_item.mag = w_mag;
        o_item.cap = r_cap;
    end

endmodule
`default_nettype wire

### src/grm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_fifo
// Short queue between the input stage and the execution stage.
// ----------------------------------------------------------------------------
module grm_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire grm_pkg::t_item i_item,
    output logic                o_ready,
    input  wire logic           i_pop,
    output logic                o_vld,
    output grm_pkg::t_item      o_item
);
    import grm_pkg::*;

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_AW:0]    r_cnt;

    assign o_ready = r_cnt != (Q_AW + 1)'(Q_DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

### src/grm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [grm_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [grm_pkg::CNT_W-1:0]    i_divisor,
    output logic                              o_busy,
    output logic [grm_pkg::DIV_W-1:0]         o_quot
);
    import grm_pkg::*;

    localparam int ITER_W = $clog2(DIV_W + 1);

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [DIV_W-1:0]  r_quo;
    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_W:0]    w_sh;
    logic              w_ge;

    assign w_sh   = {r_rem[CNT_W-1:0], r_quo[DIV_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dsr};
    assign o_busy = r_busy;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(DIV_W);
        end else if (r_busy) begin
            r_iter <= r_iter - ITER_W'(1);
            if (r_iter == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sh - {1'b0, r_dsr} : w_sh;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

### src/grm_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_sqrt
// Floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module grm_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [grm_pkg::SQ_W-1:0]    i_value,
    output logic                             o_busy,
    output logic [grm_pkg::MAG_W-1:0]        o_root
);
    import grm_pkg::*;

    localparam int ITER_W = $clog2(MAG_W + 1);

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [SQ_W-1:0]   r_val;
    logic [MAG_W-1:0]  r_root;
    logic [MAG_W+2:0]  r_rem;
    logic [MAG_W+2:0]  w_sh;
    logic [MAG_W+2:0]  w_trial;
    logic              w_ge;

    // bring down two radicand bits, try (root << 2) | 1
    assign w_sh    = {r_rem[MAG_W:0], r_val[SQ_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_sh >= w_trial;
    assign o_busy  = r_busy;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(MAG_W);
        end else if (r_busy) begin
            r_iter <= r_iter - ITER_W'(1);
            if (r_iter == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_sh - w_trial : w_sh;
            r_root <= {r_root[MAG_W-2:0], w_ge};
        end
    end

endmodule
`default_nettype wire

### src/grm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grm_back
// Execution stage: window statistics, gate and period logic, window close
// sequencing and the result register.
// ----------------------------------------------------------------------------
module grm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire grm_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_q_vld,
    input  wire grm_pkg::t_item   i_q_item,
    output logic                  o_q_pop,
    output logic                  o_out_vld,
    output grm_pkg::t_result      o_out,
    input  wire logic             i_out_ready
);
    import grm_pkg::*;

    localparam int PSUM_W = TIMER_BITS + OVF_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV_SQ = 3'b010,
        ST_DIV_DC = 3'b100
    } t_state;

    logic [CFG_W-1:0]        r_ovf_limit;
    logic [OFS_W-1:0]        r_cap_ofs;

    t_state                  r_state,   n_state;
    logic                    r_gate,    n_gate;
    logic [OVF_W-1:0]        r_ovf_cnt, n_ovf_cnt;
    logic [SQSUM_W-1:0]      r_sq_sum,  n_sq_sum;
    logic signed [SUM_W-1:0] r_sum,     n_sum;
    logic [MAG_W-1:0]        r_peak,    n_peak;
    logic [CNT_W-1:0]        r_cnt,     n_cnt;
    logic [MAG_W-1:0]        r_rms,     n_rms;
    logic signed [MV_W-1:0]  r_dc,      n_dc;
    logic [MV_W-1:0]         r_vpp,     n_vpp;
    logic [PERIOD_W-1:0]     r_period,  n_period;
    logic                    r_out_vld, n_out_vld;
    t_result                 r_out,     n_out;

    logic                    w_pop;
    logic                    w_emit;
    logic                    w_done;
    logic                    w_is_sample;
    logic                    w_has_ovf;
    logic                    w_has_cap;
    logic                    w_ovf_lt;
    logic [OVF_W-1:0]        w_ovf_new;
    logic                    w_gate_new;
    logic [PSUM_W-1:0]       w_ovf_ext;
    logic [PSUM_W-1:0]       w_psum;
    logic [SQ_W-1:0]         w_square;
    logic [SUM_W-1:0]        w_sum_abs;
    logic [MAG_W-1:0]        w_dcq;
    logic signed [MV_W-1:0]  w_dc;
    logic signed [MV_W:0]    w_diff;
    logic [MV_W-1:0]         w_vpp;

    logic                    w_div_start;
    logic [DIV_W-1:0]        w_div_dividend;
    logic                    w_div_busy;
    logic [DIV_W-1:0]        w_div_quot;
    logic                    w_sqrt_start;
    logic                    w_sqrt_busy;
    logic [MAG_W-1:0]        w_sqrt_root;

    grm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_cnt),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot)
    );

    grm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (w_div_quot[SQ_W-1:0]),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_sqrt_root)
    );

    assign w_pop       = (r_state == ST_IDLE) && i_q_vld && (!r_out_vld || i_out_ready);
    assign o_q_pop     = w_pop;
    assign o_out_vld   = r_out_vld;
    assign o_out       = r_out;

    assign w_is_sample = i_q_item.op == OP_SAMPLE;
    assign w_has_ovf   = (i_q_item.op == OP_OVF) || (i_q_item.op == OP_OVF_CAP);
    assign w_has_cap   = (i_q_item.op == OP_CAP) || (i_q_item.op == OP_OVF_CAP);
    assign w_ovf_lt    = r_ovf_cnt < r_ovf_limit;
    assign w_ovf_new   = (w_has_ovf && w_ovf_lt) ? r_ovf_cnt + OVF_W'(1) : r_ovf_cnt;
    // overflow at limit and capture each toggle the gate
    assign w_gate_new  = r_gate ^ (w_has_ovf && !w_ovf_lt) ^ w_has_cap;

    // count*(2^TIMER_BITS-1) as shift minus count
    assign w_ovf_ext   = PSUM_W'(w_ovf_new);
    assign w_psum      = PSUM_W'(i_q_item.cap) + (w_ovf_ext << TIMER_BITS) - w_ovf_ext
                         + PSUM_W'(r_cap_ofs);

    assign w_square    = i_q_item.mag * i_q_item.mag;

    // signed mean as sign and magnitude quotient, truncating toward zero
    assign w_sum_abs   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_dcq       = w_div_quot[MAG_W-1:0];
    assign w_dc        = r_sum[SUM_W-1] ? -$signed({1'b0, w_dcq}) : $signed({1'b0, w_dcq});
    assign w_diff      = $signed({2'b00, r_peak}) - $signed({2'b00, w_dcq});
    assign w_vpp       = w_diff[MV_W] ? '0 : {w_diff[MV_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_limit <= OVF_LIMIT_RST;
            r_cap_ofs   <= CAP_OFFSET_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                CFG_OVF_LIMIT: begin
                    r_ovf_limit <= i_cfg.data;
                end
                CFG_CAP_OFFSET: begin
                    r_cap_ofs <= i_cfg.data[OFS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state        = r_state;
        n_gate         = r_gate;
        n_ovf_cnt      = r_ovf_cnt;
        n_sq_sum       = r_sq_sum;
        n_sum          = r_sum;
        n_peak         = r_peak;
        n_cnt          = r_cnt;
        n_rms          = r_rms;
        n_dc           = r_dc;
        n_vpp          = r_vpp;
        n_period       = r_period;
        n_out_vld      = r_out_vld && !i_out_ready;
        n_out          = r_out;
        w_emit         = 1'b0;
        w_done         = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = r_sq_sum;
        w_sqrt_start   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    if (w_is_sample) begin
                        if (r_gate && (r_cnt != '1)) begin
                            n_sq_sum = r_sq_sum + SQSUM_W'(w_square);
                            n_sum    = r_sum + SUM_W'(i_q_item.mv);
                            n_peak   = (i_q_item.mag > r_peak) ? i_q_item.mag : r_peak;
                            n_cnt    = r_cnt + CNT_W'(1);
                        end
                        if (!r_gate && (r_cnt != '0)) begin
                            w_div_start = 1'b1;
                            n_state     = ST_DIV_SQ;
                        end else begin
                            w_emit = 1'b1;
                        end
                    end else begin
                        n_gate    = w_gate_new;
                        n_ovf_cnt = w_has_cap ? '0 : w_ovf_new;
                        if (w_has_cap) begin
                            n_period = w_psum[PERIOD_W-1:0];
                        end
                        w_emit = 1'b1;
                    end
                end
            end
            ST_DIV_SQ: begin
                if (!w_div_busy) begin
                    w_div_start    = 1'b1;
                    w_div_dividend = DIV_W'(w_sum_abs);
                    w_sqrt_start   = 1'b1;
                    n_state        = ST_DIV_DC;
                end
            end
            ST_DIV_DC: begin
                if (!w_div_busy && !w_sqrt_busy) begin
                    n_rms    = w_sqrt_root;
                    n_dc     = w_dc;
                    n_vpp    = w_vpp;
                    n_sq_sum = '0;
                    n_sum    = '0;
                    n_peak   = '0;
                    n_cnt    = '0;
                    w_emit   = 1'b1;
                    w_done   = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit) begin
            n_out_vld     = 1'b1;
            n_out.done    = w_done;
            n_out.gate    = n_gate;
            n_out.period  = n_period;
            n_out.vpp     = n_vpp;
            n_out.dc      = n_dc;
            n_out.rms     = n_rms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gate    <= 1'b0;
            r_ovf_cnt <= '0;
            r_sq_sum  <= '0;
            r_sum     <= '0;
            r_peak    <= '0;
            r_cnt     <= '0;
            r_rms     <= '0;
            r_dc      <= '0;
            r_vpp     <= '0;
            r_period  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gate    <= n_gate;
            r_ovf_cnt <= n_ovf_cnt;
            r_sq_sum  <= n_sq_sum;
            r_sum     <= n_sum;
            r_peak    <= n_peak;
            r_cnt     <= n_cnt;
            r_rms     <= n_rms;
            r_dc      <= n_dc;
            r_vpp     <= n_vpp;
            r_period  <= n_period;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule
`default_nettype wire

### src/gated_rms_dc_vpp_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gated_rms_dc_vpp_meter
// Gated voltage meter: RMS, mean and peak-to-peak estimate of ADC samples
// over a window opened and closed by timer events, plus the captured period.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer: tuser is the op (sample, overflow,
//   capture, overflow then capture), tdata holds the sample and capture count.
//   m_axis returns exactly one result per input item, in order.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; index 0 is the overflow limit, 1 the capture offset.
// Timing:
//   Samples and timer events pass the input stage register, the queue and
//   the execution stage into the result register; the execution stage
//   takes a new item while idle and the result register is free or
//   being taken. The first sample after the gate closes, if the window
//   holds samples, runs two serial divisions on the shared divider, with
//   the square root overlapped with the second division. A 4-entry queue
//   keeps s_axis taking transfers until it fills.
// Reset and stall:
//   Synchronous reset clears all statistics, the gate, the results and the
//   queue, and restores the register defaults. When m_axis_tready is low
//   the result holds, the execution stage waits and the queue fills before
//   s_axis_tready drops.
// ----------------------------------------------------------------------------
module gated_rms_dc_vpp_meter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [grm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [grm_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: sample, capture_count
    input  wire logic [grm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: op
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: rms_mv, dc_mv, vpp_mv, period_ticks
    output logic [grm_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // tuser: gate_open, window_done
    output logic [1:0]                             m_axis_tuser
);
    import grm_pkg::*;

    t_cfg_wr w_cfg;
    logic    w_q_ready;
    logic    w_push;
    t_item   w_push_item;
    logic    w_q_vld;
    t_item   w_q_item;
    logic    w_pop;
    t_result w_out;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    grm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_op      (t_op'(s_axis_tuser)),
        .i_sample  (s_axis_tdata[ADC_BITS-1:0]),
        .i_cap     (s_axis_tdata[ADC_BITS +: TIMER_BITS]),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_item    (w_push_item)
    );

    grm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_vld   (w_q_vld),
        .o_item  (w_q_item)
    );

    grm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_vld     (w_q_vld),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_pop),
        .o_out_vld   (m_axis_tvalid),
        .o_out       (w_out),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_out.period, w_out.vpp, w_out.dc, w_out.rms});
    assign m_axis_tuser = {w_out.done, w_out.gate};

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the gated RMS / DC / Vpp meter. A queue-fed driver
// and a clocked monitor run the block; every accepted input item is run
// through a local model of the meter and the single result that it yields
// is checked field by field. The run covers directed corner items, random
// gate windows under three register settings, a long output stall and a
// stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import grm_pkg::*;

    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RAND_ITEMS   = 370;    // per random phase, two phases
    localparam int QUIET_ITEMS  = 80;
    localparam int COUNT_MAX    = 65535;

    // result field offsets in m_axis_tdata
    localparam int DC_LSB     = MAG_W;
    localparam int VPP_LSB    = DC_LSB + MV_W;
    localparam int PERIOD_LSB = VPP_LSB + MV_W;

    typedef struct packed {
        t_op                   op;
        logic [ADC_BITS-1:0]   smp;
        logic [TIMER_BITS-1:0] cap;
    } meter_item_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_OVF_LIMIT;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = OP_SAMPLE;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    gated_rms_dc_vpp_meter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    meter_item_t input_backlog[$];
    t_result     expected_readings[$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;  // no random idling on either side
    bit  in_taken    = 1'b0;  // input transfer at the last rising edge
    int  hold_req    = 0;
    int  hold_ack    = 0;
    int  hold_left   = 0;

    // meter model state
    int           mdl_ovf_limit = OVF_LIMIT_RST;
    int           mdl_cap_offset = CAP_OFFSET_RST;
    bit           mdl_gate = 1'b0;
    int           mdl_ovf_cnt = 0;
    longint       mdl_sq_sum = 0;
    longint       mdl_sum = 0;
    int           mdl_peak = 0;
    int           mdl_cnt = 0;
    int           mdl_rms = 0;
    int           mdl_dc = 0;
    int           mdl_vpp = 0;
    logic [31:0]  mdl_period = '0;

    // generator's view of the gate, used only to shape windows
    bit gen_gate = 1'b0;
    int gen_ovf = 0;
    int gen_limit = OVF_LIMIT_RST;
    int gen_pushed = 0;

    function automatic int floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            b = r | (64'd1 << k);
            if (b * b <= v) r = b;
        end
        return int'(r);
    endfunction

    function automatic void meter_timer_ovf();
        if (mdl_ovf_cnt < mdl_ovf_limit) mdl_ovf_cnt++;
        else mdl_gate = !mdl_gate;
    endfunction

    function automatic void meter_capture(logic [TIMER_BITS-1:0] cap);
        longint p;
        p = longint'(cap) + longint'(mdl_ovf_cnt) * (2**TIMER_BITS - 1)
            + longint'(mdl_cap_offset);
        mdl_period = p[31:0];
        mdl_gate = !mdl_gate;
        mdl_ovf_cnt = 0;
    endfunction

    function automatic t_result meter_step(t_op op, logic [ADC_BITS-1:0] smp,
                                           logic [TIMER_BITS-1:0] cap);
        t_result r;
        int      s;
        int      mv;
        int      mag;
        int      adc;
        bit      done;
        done = 1'b0;
        if (op == OP_SAMPLE) begin
            s = int'(smp);
            mv = (MV_SCALE * (s - MV_MID)) / MV_MID - MV_TRIM;
            mag = (mv < 0) ? -mv : mv;
            if (mdl_gate) begin
                if (mdl_cnt < COUNT_MAX) begin
                    mdl_sq_sum += longint'(mag) * mag;
                    mdl_sum += mv;
                    if (mag > mdl_peak) mdl_peak = mag;
                    mdl_cnt++;
                end
            end else if (mdl_cnt != 0) begin
                mdl_rms = floor_sqrt(mdl_sq_sum / mdl_cnt);
                mdl_dc = int'(mdl_sum / longint'(mdl_cnt));
                adc = (mdl_dc < 0) ? -mdl_dc : mdl_dc;
                mdl_vpp = (mdl_peak < adc) ? 0 : 2 * (mdl_peak - adc);
                mdl_sq_sum = 0;
                mdl_sum = 0;
                mdl_peak = 0;
                mdl_cnt = 0;
                done = 1'b1;
            end
        end else begin
            if (op == OP_OVF || op == OP_OVF_CAP) meter_timer_ovf();
            if (op == OP_CAP || op == OP_OVF_CAP) meter_capture(cap);
        end
        r.rms    = mdl_rms[MAG_W-1:0];
        r.dc     = mdl_dc[MV_W-1:0];
        r.vpp    = mdl_vpp[MV_W-1:0];
        r.period = mdl_period;
        r.gate   = mdl_gate;
        r.done   = done;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic push_item(t_op op, logic [ADC_BITS-1:0] smp,
                             logic [TIMER_BITS-1:0] cap);
        meter_item_t it;
        it.op  = op;
        it.smp = smp;
        it.cap = cap;
        if (op == OP_OVF || op == OP_OVF_CAP) begin
            if (gen_ovf < gen_limit) gen_ovf++;
            else gen_gate = !gen_gate;
        end
        if (op == OP_CAP || op == OP_OVF_CAP) begin
            gen_gate = !gen_gate;
            gen_ovf = 0;
        end
        input_backlog.push_back(it);
        gen_pushed++;
    endtask

    function automatic logic [ADC_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return ADC_BITS'(MV_MID + $urandom_range(4) - 2);
            default: return ADC_BITS'($urandom_range(2**ADC_BITS - 1));
        endcase
    endfunction

    // timer events until the gate has flipped
    task automatic push_toggle();
        bit g0;
        g0 = gen_gate;
        while (gen_gate == g0)
            push_item(t_op'($urandom_range(OP_OVF, OP_OVF_CAP)),
                      ADC_BITS'($urandom), TIMER_BITS'($urandom));
    endtask

    task automatic push_window();
        int n;
        if (gen_gate) begin
            push_toggle();
            push_item(OP_SAMPLE, pick_sample(), TIMER_BITS'($urandom));
        end
        push_toggle();
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
        repeat (n) push_item(OP_SAMPLE, pick_sample(), TIMER_BITS'($urandom));
        push_toggle();
        push_item(OP_SAMPLE, pick_sample(), TIMER_BITS'($urandom));
    endtask

    task automatic push_random(int target);
        int start;
        start = gen_pushed;
        while (gen_pushed - start < target) begin
            if ($urandom_range(99) < 80) push_window();
            else push_item(t_op'($urandom_range(3)), ADC_BITS'($urandom),
                           TIMER_BITS'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (input_backlog.size() != 0 || s_axis_tvalid
               || expected_readings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        if (idx == CFG_OVF_LIMIT) begin
            mdl_ovf_limit = value;
            gen_limit = value;
        end else begin
            mdl_cap_offset = value;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------- driver ----------------

    always @(negedge i_clk) begin : drive_in
        meter_item_t cur;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (input_backlog.size() != 0
                && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                cur = input_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur.op;
                s_axis_tdata  <= IN_TDATA_W'({cur.cap, cur.smp});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.rms    = m_axis_tdata[MAG_W-1:0];
                got.dc     = m_axis_tdata[DC_LSB +: MV_W];
                got.vpp    = m_axis_tdata[VPP_LSB +: MV_W];
                got.period = m_axis_tdata[PERIOD_LSB +: PERIOD_W];
                got.gate   = m_axis_tuser[0];
                got.done   = m_axis_tuser[1];
                if (expected_readings.size() == 0) begin
                    $error("result transfer with nothing pending: tdata=%h tuser=%b",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.rms !== want.rms) begin
                        $error("rms_mv: expected %0d, got %0d", want.rms, got.rms);
                        fail_count++;
                    end
                    if (got.dc !== want.dc) begin
                        $error("dc_mv: expected %0d, got %0d", want.dc, got.dc);
                        fail_count++;
                    end
                    if (got.vpp !== want.vpp) begin
                        $error("vpp_mv: expected %0d, got %0d", want.vpp, got.vpp);
                        fail_count++;
                    end
                    if (got.period !== want.period) begin
                        $error("period_ticks: expected %0d, got %0d",
                               want.period, got.period);
                        fail_count++;
                    end
                    if (got.gate !== want.gate) begin
                        $error("gate_open: expected %0b, got %0b", want.gate, got.gate);
                        fail_count++;
                    end
                    if (got.done !== want.done) begin
                        $error("window_done: expected %0b, got %0b",
                               want.done, got.done);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_readings.push_back(meter_step(t_op'(s_axis_tuser),
                    s_axis_tdata[ADC_BITS-1:0],
                    s_axis_tdata[ADC_BITS +: TIMER_BITS]));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, register defaults
        push_item(OP_SAMPLE, ADC_BITS'(MV_MID), '0);      // closed gate, empty window
        push_item(OP_CAP, '0, '1);                         // open
        push_item(OP_SAMPLE, '0, '0);
        push_item(OP_SAMPLE, '1, '0);
        push_item(OP_SAMPLE, ADC_BITS'(MV_MID), '0);
        push_item(OP_SAMPLE, ADC_BITS'(MV_MID + 1), '0);
        push_item(OP_SAMPLE, ADC_BITS'(MV_MID - 1), '0);
        push_item(OP_SAMPLE, 14'h2AAA, 16'h5555);
        push_item(OP_OVF, '1, '1);                         // counts only
        push_item(OP_OVF_CAP, '0, '0);                     // close, period uses 2 overflows
        push_item(OP_SAMPLE, 14'h1555, 16'hAAAA);          // window close
        push_item(OP_SAMPLE, '0, '0);                      // ignored
        push_item(OP_CAP, '0, 16'h5555);
        push_item(OP_SAMPLE, '0, '0);
        push_item(OP_CAP, '0, 16'hAAAA);
        push_item(OP_SAMPLE, '1, '0);                      // single-sample window
        wait_idle();

        // zero limit: every overflow toggles the gate
        write_reg(CFG_OVF_LIMIT, 0);
        write_reg(CFG_CAP_OFFSET, 1023);
        push_item(OP_OVF, '0, '0);
        push_item(OP_SAMPLE, '1, '0);
        push_item(OP_SAMPLE, '1, '0);
        push_item(OP_SAMPLE, 14'd16000, '0);
        push_item(OP_OVF_CAP, '0, '1);                     // toggles twice
        push_item(OP_OVF, '0, '0);
        push_item(OP_SAMPLE, ADC_BITS'(MV_MID), '0);
        push_item(OP_CAP, '0, '0);
        push_item(OP_OVF, '0, '0);
        push_item(OP_SAMPLE, '0, '0);                      // empty window, ignored
        wait_idle();

        // random, with a long output stall while the input keeps offering
        push_random(RAND_ITEMS);
        hold_req = hold_req + 1;
        wait_idle();

        write_reg(CFG_OVF_LIMIT, 3);
        write_reg(CFG_CAP_OFFSET, 0);
        push_random(RAND_ITEMS);
        wait_idle();

        // top of the limit range, no idling on either side
        write_reg(CFG_OVF_LIMIT, 65535);
        write_reg(CFG_CAP_OFFSET, 512);
        quiet = 1'b1;
        push_random(QUIET_ITEMS);
        wait_idle();
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_readings.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
